@@ rtl/rla_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rla_pkg
// shared widths, codes and controller/datapath interface types for the
// running lcm accumulator
// ----------------------------------------------------------------------------
package rla_pkg;

	// operand width and derived sizes
	localparam int DATA_WIDTH = 31;
	localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam logic [DATA_WIDTH-1:0] LCM_MAX = {DATA_WIDTH{1'b1}};

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_DIV,
		S_MUL,
		S_FIN
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic mul;
		logic fin;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic fast;
		logic gcd_done;
		logic div_last;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/rla_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rla_dpath
// datapath: running lcm register, binary gcd, restoring divider,
// multiply with overflow check and result register
// ----------------------------------------------------------------------------
module rla_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rla_pkg::cmd_t                 cmd,
	input  wire logic [rla_pkg::DATA_WIDTH-1:0] in_value,
	input  wire logic                          in_start,
	output rla_pkg::dp_stat_t                  stat,
	output logic [rla_pkg::DATA_WIDTH-1:0]     res_lcm,
	output rla_pkg::status_t                   res_status
);
	import rla_pkg::*;

	logic [DATA_WIDTH-1:0] lcm_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic                  start_q;
	logic [DATA_WIDTH-1:0] a_q, b_q;
	logic [CNT_W-1:0]      k_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DATA_WIDTH-1:0] res_lcm_q;
	status_t               res_status_q;

	logic [DATA_WIDTH-1:0] a_nxt, b_nxt;
	logic [CNT_W-1:0]      k_nxt;
	logic [DATA_WIDTH:0]   rem_sh, rem_sub;
	logic                  q_bit;
	logic [DATA_WIDTH-1:0] lcm_nxt;
	status_t               st_nxt;

	// status to controller
	assign stat.fast     = (v_q == '0) || start_q || (lcm_q == '0);
	assign stat.gcd_done = (a_q == b_q);
	assign stat.div_last = (cnt_q == '0);

	// one binary gcd step
	always_comb begin
		a_nxt = a_q;
		b_nxt = b_q;
		k_nxt = k_q;
		if (!a_q[0] && !b_q[0]) begin
			a_nxt = a_q >> 1;
			b_nxt = b_q >> 1;
			k_nxt = k_q + CNT_W'(1);
		end else if (!a_q[0]) begin
			a_nxt = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nxt = b_q >> 1;
		end else if (a_q > b_q) begin
			a_nxt = (a_q - b_q) >> 1;
		end else begin
			b_nxt = (b_q - a_q) >> 1;
		end
	end

	// one restoring division step
	always_comb begin
		rem_sh  = {rem_q, quo_q[DATA_WIDTH-1]};
		q_bit   = (rem_sh >= {1'b0, dsr_q});
		rem_sub = q_bit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// final result selection
	always_comb begin
		lcm_nxt = lcm_q;
		st_nxt  = ST_OK;
		if (v_q == '0) begin
			st_nxt = ST_ZERO;
		end else if (start_q || (lcm_q == '0)) begin
			lcm_nxt = v_q;
		end else if (|prod_q[PROD_W-1:DATA_WIDTH]) begin
			lcm_nxt = LCM_MAX;
			st_nxt  = ST_OVF;
		end else begin
			lcm_nxt = prod_q[DATA_WIDTH-1:0];
		end
	end

	// running lcm state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcm_q <= DATA_WIDTH'(1);
		end else if (cmd.fin) begin
			lcm_q <= lcm_nxt;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q     <= in_value;
			start_q <= in_start;
			a_q     <= lcm_q;
			b_q     <= in_value;
			k_q     <= '0;
		end else if (cmd.gcd_step) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
			k_q <= k_nxt;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= lcm_q;
			dsr_q <= a_q << k_q;
			cnt_q <= CNT_W'(DATA_WIDTH - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_sub[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(quo_q) * PROD_W'(v_q);
		end
		if (cmd.fin) begin
			res_lcm_q    <= lcm_nxt;
			res_status_q <= st_nxt;
		end
	end

	assign res_lcm    = res_lcm_q;
	assign res_status = res_status_q;

endmodule
`default_nettype wire

@@ rtl/rla_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rla_ctrl
// controller: sequences gcd, divide, multiply and result hand-off,
// owns the stream handshakes
// ----------------------------------------------------------------------------
module rla_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire rla_pkg::dp_stat_t stat,
	output rla_pkg::cmd_t          cmd
);
	import rla_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_GCD;
				end
			end
			S_GCD: begin
				if (stat.fast) begin
					state_nxt = S_FIN;
				end else if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_nxt    = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/running_lcm_accumulator.sv @@
// a zero or start item goes from the input transfer straight to the result register;
// otherwise it runs through the binary gcd steps, DATA_WIDTH restoring divide steps,
// the multiply and then the result register
// one item is in work at a time; the next item is taken once the result
// is in the output register, which may still wait for the downstream transfer
// reset: arst_n clears control and sets the running lcm to one
`default_nettype none
// ----------------------------------------------------------------------------
// running_lcm_accumulator
// keeps the least common multiple of a stream of integers, with set restart,
// zero rejection and overflow saturation
// ----------------------------------------------------------------------------
module running_lcm_accumulator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [rla_pkg::TDATA_W-1:0] s_tdata,  // value
	input  wire logic                       s_tuser,  // start_set
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [rla_pkg::TDATA_W-1:0]     m_tdata,  // lcm_so_far
	output logic [1:0]                      m_tuser   // status
);
	import rla_pkg::*;

	cmd_t                  cmd;
	dp_stat_t              stat;
	logic [DATA_WIDTH-1:0] res_lcm;
	status_t               res_status;

	// sequencer
	rla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic
	rla_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_value   (s_tdata[DATA_WIDTH-1:0]),
		.in_start   (s_tuser),
		.stat       (stat),
		.res_lcm    (res_lcm),
		.res_status (res_status)
	);

	// result packing
	assign m_tdata = TDATA_W'(res_lcm);
	assign m_tuser = res_status;

endmodule
`default_nettype wire

@@ rtl/rla_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rla_checker
// port-level checks for the running lcm accumulator
// ----------------------------------------------------------------------------
module rla_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [rla_pkg::TDATA_W-1:0] m_tdata,
	input wire logic [1:0]                 m_tuser
);
	import rla_pkg::*;

	// one item in flight: input closes after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in work");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO || m_tuser == ST_OVF))
		else $error("undefined status code");

	// running lcm never reads zero
	a_lcm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[DATA_WIDTH-1:0] != '0))
		else $error("zero lcm reported");

	// stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

endmodule

bind running_lcm_accumulator rla_checker u_rla_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/sv/running_lcm_accumulator_tb.sv @@
// ----------------------------------------------------------------------------
// running_lcm_accumulator_tb
// drives value/start transfers into the lcm accumulator and checks every
// result transfer against a predictor of the running lcm, with zero
// rejection, set restart and overflow saturation; directed rows first, then
// random sets of mostly small values so that the lcm grows into saturation
// ----------------------------------------------------------------------------
module running_lcm_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rla_pkg::*;

	localparam int NUM_ITEMS = 750;
	localparam int NUM_DIR   = 23;
	localparam int HOLD_AT   = 500;
	localparam int HOLD_LEN  = 400;

	typedef logic [DATA_WIDTH-1:0] val_t;

	typedef struct packed {
		val_t    lcm;
		status_t st;
	} lcm_result_t;

	typedef struct packed {
		val_t        value;
		logic        start;
		logic        typed;
		lcm_result_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // value
	logic               s_tuser;   // start_set
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // lcm_so_far
	logic [1:0]         m_tuser;   // status

	val_t        acc_lcm;
	lcm_result_t expected_q[$];
	dir_row_t    dir_table[NUM_DIR];
	int          items_sent   = 0;
	int          results_seen = 0;
	int          mismatches   = 0;
	bit          sender_idles = 1'b1;

	running_lcm_accumulator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// euclid on wide operands
	function automatic logic [63:0] gcd_wide(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		while (b != 64'd0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// advance the running lcm by one item and return the result it yields
	task automatic update_lcm(input val_t v, input logic st, output lcm_result_t res);
		logic [63:0] g;
		logic [63:0] q;
		res.st = ST_OK;
		if (v == '0) begin
			res.st = ST_ZERO;
		end else if (st || acc_lcm == '0) begin
			acc_lcm = v;
		end else begin
			g = gcd_wide(64'(acc_lcm), 64'(v));
			q = 64'(acc_lcm) / g;
			if (q > 64'(LCM_MAX) / 64'(v)) begin
				acc_lcm = LCM_MAX;
				res.st  = ST_OVF;
			end else begin
				acc_lcm = val_t'(q * 64'(v));
			end
		end
		res.lcm = acc_lcm;
	endtask

	// offer one item and queue its result once the transfer happens
	task automatic offer_value(input val_t v, input logic st, input logic typed,
	                           input lcm_result_t typed_res);
		lcm_result_t res;
		while (sender_idles && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W - DATA_WIDTH){1'b0}}, v};
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		update_lcm(v, st, res);
		expected_q.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	// receiver: random ready, a quiet window, one long hold-off; checks results
	initial begin
		lcm_result_t exp_res;
		int          hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: lcm_so_far=%0d status=%0d",
					       m_tdata[DATA_WIDTH-1:0], m_tuser);
					mismatches++;
				end else begin
					exp_res = expected_q.pop_front();
					if (m_tdata[DATA_WIDTH-1:0] !== exp_res.lcm) begin
						$error("lcm_so_far: expected %0d, actual %0d",
						       exp_res.lcm, m_tdata[DATA_WIDTH-1:0]);
						mismatches++;
					end
					if (m_tuser !== exp_res.st) begin
						$error("status: expected %0d, actual %0d", exp_res.st, m_tuser);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				m_tready  <= 1'b0;
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end else if (results_seen >= 250 && results_seen < 400) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 24);
			end
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin
		lcm_result_t no_res;
		val_t        v;
		logic        st;
		int          set_len;
		int          pick;
		no_res   = '{lcm: '0, st: ST_OK};
		acc_lcm  = val_t'(1);
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;

		// value, start, typed, expected lcm, expected status
		dir_table = '{
			'{31'd6,          1'b0, 1'b1, '{31'd6,          ST_OK}},   // first item after reset
			'{31'd0,          1'b0, 1'b1, '{31'd6,          ST_ZERO}},
			'{31'd4,          1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd0,          1'b1, 1'b1, '{31'd12,         ST_ZERO}}, // zero ignores start
			'{LCM_MAX,        1'b1, 1'b1, '{LCM_MAX,        ST_OK}},
			'{31'd1,          1'b0, 1'b1, '{LCM_MAX,        ST_OK}},
			'{31'd2,          1'b0, 1'b1, '{LCM_MAX,        ST_OVF}},
			'{LCM_MAX,        1'b0, 1'b0, '{31'd0,          ST_OK}},   // from saturated value
			'{31'd3,          1'b0, 1'b1, '{LCM_MAX,        ST_OVF}},
			'{31'd1,          1'b1, 1'b1, '{31'd1,          ST_OK}},
			'{31'd12,         1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd18,         1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd36,         1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd7,          1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'h4000_0000,  1'b1, 1'b1, '{31'h4000_0000,  ST_OK}},
			'{31'd2,          1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd3,          1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd1,          1'b1, 1'b1, '{31'd1,          ST_OK}},
			'{31'd65536,      1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd32768,      1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'd46337,      1'b0, 1'b0, '{31'd0,          ST_OK}},
			'{31'h5555_5555,  1'b1, 1'b1, '{31'h5555_5555,  ST_OK}},
			'{31'h2AAA_AAAA,  1'b0, 1'b0, '{31'd0,          ST_OK}}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int i = 0; i < NUM_DIR; i++)
			offer_value(dir_table[i].value, dir_table[i].start, dir_table[i].typed,
			            dir_table[i].res);

		// random sets: mostly small values so the lcm climbs toward saturation
		while (items_sent < NUM_ITEMS) begin
			set_len = $urandom_range(1, 24);
			for (int k = 0; k < set_len; k++) begin
				sender_idles = !(items_sent >= 300 && items_sent < 420);
				st = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 6)
					v = '0;
				else if (pick < 55)
					v = val_t'($urandom_range(1, 40));
				else if (pick < 75)
					v = val_t'($urandom_range(1, 4096));
				else if (pick < 90)
					v = val_t'($urandom());
				else if (pick < 95)
					v = val_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
				else
					v = LCM_MAX - val_t'($urandom_range(0, 3));
				offer_value(v, st, 1'b0, no_res);
			end
		end
		s_tvalid <= 1'b0;

		// drain
		while (expected_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rla_pkg.sv
rtl/rla_dpath.sv
rtl/rla_ctrl.sv
rtl/running_lcm_accumulator.sv
rtl/rla_checker.sv
tb/sv/running_lcm_accumulator_tb.sv
